>>> hw/rtl/gear_ratio_matcher_core_assert.svh
// Assertion macros for the gear ratio matcher checkers.
// Both expect aclk and aresetn in scope; checks are off while reset is low.
`ifndef GEAR_RATIO_MATCHER_CORE_ASSERT_SVH
`define GEAR_RATIO_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/grm_pkg.sv
`timescale 1ns / 1ps
package grm_pkg;

    localparam int MAX_FRONT  = 3;
    localparam int MAX_REAR   = 12;
    localparam int TOOTH_W    = 8;
    localparam int RATIO_W    = 16;
    localparam int FRAC_W     = 12;
    localparam int FRONT_W    = 2;
    localparam int REAR_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PROD_W     = RATIO_W + TOOTH_W;
    localparam int FI_W       = (MAX_FRONT > 1) ? $clog2(MAX_FRONT) : 1;
    localparam int RI_W       = (MAX_REAR > 1) ? $clog2(MAX_REAR) : 1;

    typedef logic [FRONT_W-1:0] front_num_t;
    typedef logic [REAR_W-1:0]  rear_num_t;
    typedef logic [FI_W-1:0]    front_idx_t;
    typedef logic [RI_W-1:0]    rear_idx_t;
    typedef logic [TOOTH_W-1:0] tooth_t;
    typedef logic [RATIO_W-1:0] ratio_t;
    typedef logic [PROD_W-1:0]  prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRONT_COUNT = 3'd0,
        REG_FRONT_TEETH = 3'd1,
        REG_REAR_COUNT  = 3'd2,
        REG_REAR_LOW    = 3'd3,
        REG_REAR_HIGH   = 3'd4,
        REG_TOLERANCE   = 3'd5
    } cfg_reg_t;

    // Decoded configuration seen by the sequencer
    typedef struct packed {
        front_num_t                  nf;
        rear_num_t                   nr;
        ratio_t                      tol;
        tooth_t [MAX_FRONT-1:0]      front;
        tooth_t [MAX_REAR-1:0]       rear;
    } cfg_t;

    // Operands of one gear pair handed to the compare unit
    typedef struct packed {
        ratio_t ratio;
        tooth_t ft;
        tooth_t rt;
        ratio_t tol;
    } pair_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } seq_state_t;

endpackage

>>> hw/rtl/gear_ratio_matcher_core.sv
`timescale 1ns / 1ps
// Gear ratio matcher. Each request carries a measured front-to-rear ratio in
// unsigned Q4.12 and returns the first configured gear pair, scanned with the
// front chainring outer and the rear sprocket inner, for which
// |ratio * rear - front * 4096| <= tolerance * rear, as 1-based indices with
// found set; if no pair matches, found and both indices are zero. A rear
// sprocket with zero teeth never matches, and counts above the table size
// saturate. Each request examines the pairs in that order until one
// matches, at most front_count * rear_count of them (at most 36; none if a
// count is zero); a single pair comparator with two 16x8 multipliers is
// stepped through the pairs once per cycle, then the result moves to the
// output register, and only then is the next request accepted. A finished
// result may wait in the output register while the next request is taken.
// Configuration writes are always accepted and must only be issued while no
// request is in flight; unknown register indexes are dropped.
module gear_ratio_matcher_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [grm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_measured_ratio,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [1:0]                         m_front_gear,
    output logic [3:0]                         m_rear_gear
);

    grm_pkg::cfg_t     cfg;
    grm_pkg::pair_op_t op;
    logic              match;

    // register writes never stall
    assign cfg_ready = 1'b1;

    grm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    // shared comparator: one gear pair per cycle
    grm_pair_unit u_pair (
        .op    (op),
        .match (match)
    );

    grm_seq u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_ratio (s_measured_ratio),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_front_gear     (m_front_gear),
        .m_rear_gear      (m_rear_gear),
        .op               (op),
        .match            (match)
    );

endmodule

>>> hw/rtl/grm_cfg.sv
`timescale 1ns / 1ps
module grm_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [grm_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [grm_pkg::CFG_DATA_W-1:0]      wr_data,
    output grm_pkg::cfg_t                       cfg
);

    logic [1:0]  front_count_reg;
    logic [23:0] front_teeth_reg;
    logic [3:0]  rear_count_reg;
    logic [63:0] rear_low_reg;
    logic [31:0] rear_high_reg;
    logic [15:0] tol_reg;
    logic [95:0] rear_all;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_count_reg <= 2'd1;
            front_teeth_reg <= '0;
            rear_count_reg  <= 4'd1;
            rear_low_reg    <= '0;
            rear_high_reg   <= '0;
            tol_reg         <= '0;
        end else if (wr_en) begin
            case (grm_pkg::cfg_reg_t'(wr_index))
                grm_pkg::REG_FRONT_COUNT: front_count_reg <= wr_data[1:0];
                grm_pkg::REG_FRONT_TEETH: front_teeth_reg <= wr_data[23:0];
                grm_pkg::REG_REAR_COUNT:  rear_count_reg  <= wr_data[3:0];
                grm_pkg::REG_REAR_LOW:    rear_low_reg    <= wr_data[63:0];
                grm_pkg::REG_REAR_HIGH:   rear_high_reg   <= wr_data[31:0];
                grm_pkg::REG_TOLERANCE:   tol_reg         <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign rear_all = {rear_high_reg, rear_low_reg};

    always_comb begin
        // saturate counts to the table size
        cfg.nf  = (front_count_reg > grm_pkg::MAX_FRONT)
                  ? grm_pkg::front_num_t'(grm_pkg::MAX_FRONT) : front_count_reg;
        cfg.nr  = (rear_count_reg > grm_pkg::MAX_REAR)
                  ? grm_pkg::rear_num_t'(grm_pkg::MAX_REAR) : rear_count_reg;
        cfg.tol = tol_reg;
        for (int i = 0; i < grm_pkg::MAX_FRONT; i++) begin
            cfg.front[i] = front_teeth_reg[i*grm_pkg::TOOTH_W +: grm_pkg::TOOTH_W];
        end
        for (int i = 0; i < grm_pkg::MAX_REAR; i++) begin
            cfg.rear[i] = rear_all[i*grm_pkg::TOOTH_W +: grm_pkg::TOOTH_W];
        end
    end

endmodule

>>> hw/rtl/grm_pair_unit.sv
`timescale 1ns / 1ps
module grm_pair_unit (
    input  grm_pkg::pair_op_t op,
    output logic              match
);

    grm_pkg::prod_t scaled_ratio;
    grm_pkg::prod_t scaled_tol;
    grm_pkg::prod_t front_q;
    grm_pkg::prod_t diff;

    always_comb begin
        scaled_ratio = grm_pkg::prod_t'(op.ratio) * grm_pkg::prod_t'(op.rt);
        scaled_tol   = grm_pkg::prod_t'(op.tol) * grm_pkg::prod_t'(op.rt);
        front_q      = grm_pkg::prod_t'({op.ft, {grm_pkg::FRAC_W{1'b0}}});
        diff         = (scaled_ratio > front_q) ? (scaled_ratio - front_q)
                                                : (front_q - scaled_ratio);
        // a sprocket with no teeth never matches
        match        = (op.rt != '0) && (diff <= scaled_tol);
    end

endmodule

>>> hw/rtl/grm_seq.sv
`timescale 1ns / 1ps
module grm_seq (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  grm_pkg::cfg_t            cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  grm_pkg::ratio_t          s_measured_ratio,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_found,
    output grm_pkg::front_num_t      m_front_gear,
    output grm_pkg::rear_num_t       m_rear_gear,
    output grm_pkg::pair_op_t        op,
    input  logic                     match
);

    grm_pkg::seq_state_t state_reg, state_next;
    grm_pkg::front_idx_t f_reg;
    grm_pkg::rear_idx_t  r_reg;
    grm_pkg::ratio_t     ratio_reg;
    logic                res_found_reg;
    grm_pkg::front_num_t res_front_reg;
    grm_pkg::rear_num_t  res_rear_reg;
    logic                m_valid_reg;
    logic                m_found_reg;
    grm_pkg::front_num_t m_front_reg;
    grm_pkg::rear_num_t  m_rear_reg;

    logic accept;
    logic no_pairs;
    logic last_f;
    logic last_r;
    logic out_free;

    assign accept   = s_valid && s_ready;
    assign no_pairs = (cfg.nf == '0) || (cfg.nr == '0);
    assign last_f   = grm_pkg::front_num_t'(f_reg) == (cfg.nf - grm_pkg::front_num_t'(1));
    assign last_r   = grm_pkg::rear_num_t'(r_reg) == (cfg.nr - grm_pkg::rear_num_t'(1));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grm_pkg::ST_IDLE: if (accept) begin
                state_next = no_pairs ? grm_pkg::ST_HOLD : grm_pkg::ST_SCAN;
            end
            grm_pkg::ST_SCAN: if (match || (last_f && last_r)) begin
                state_next = grm_pkg::ST_HOLD;
            end
            grm_pkg::ST_HOLD: if (out_free) begin
                state_next = grm_pkg::ST_IDLE;
            end
            default: state_next = grm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == grm_pkg::ST_IDLE);
        op.ratio = ratio_reg;
        op.ft    = cfg.front[f_reg];
        op.rt    = cfg.rear[r_reg];
        op.tol   = cfg.tol;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= grm_pkg::ST_IDLE;
            f_reg       <= '0;
            r_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                f_reg <= '0;
                r_reg <= '0;
            end else if (state_reg == grm_pkg::ST_SCAN && !match) begin
                // advance rear inner, front outer; hold on the last pair
                if (!last_r) begin
                    r_reg <= r_reg + grm_pkg::rear_idx_t'(1);
                end else if (!last_f) begin
                    r_reg <= '0;
                    f_reg <= f_reg + grm_pkg::front_idx_t'(1);
                end
            end
            if (state_reg == grm_pkg::ST_HOLD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ratio_reg     <= s_measured_ratio;
            res_found_reg <= 1'b0;
            res_front_reg <= '0;
            res_rear_reg  <= '0;
        end else if (state_reg == grm_pkg::ST_SCAN && match) begin
            res_found_reg <= 1'b1;
            res_front_reg <= grm_pkg::front_num_t'(f_reg) + grm_pkg::front_num_t'(1);
            res_rear_reg  <= grm_pkg::rear_num_t'(r_reg) + grm_pkg::rear_num_t'(1);
        end
        if (state_reg == grm_pkg::ST_HOLD && out_free) begin
            m_found_reg <= res_found_reg;
            m_front_reg <= res_front_reg;
            m_rear_reg  <= res_rear_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_front_gear = m_front_reg;
    assign m_rear_gear  = m_rear_reg;

endmodule

>>> hw/rtl/grm_checker.sv
`timescale 1ns / 1ps
`include "gear_ratio_matcher_core_assert.svh"
module grm_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [grm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [grm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [15:0]                        s_measured_ratio,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_found,
    input logic [1:0]                         m_front_gear,
    input logic [3:0]                         m_rear_gear
);

    // a stalled result holds
    `GRM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_front_gear) && $stable(m_rear_gear), "result changed while stalled")

    // no match reports zero indices
    `GRM_ASSERT_NOW(a_miss_zero, m_valid && !m_found, m_front_gear == 2'd0 && m_rear_gear == 4'd0, "miss with nonzero index")

    // a match reports indices within the table
    `GRM_ASSERT_NOW(a_hit_range, m_valid && m_found, m_front_gear != 2'd0 && m_rear_gear != 4'd0 && m_rear_gear <= 4'd12, "match index out of range")

    // one request at a time: busy straight after acceptance
    `GRM_ASSERT_NEXT(a_busy, s_valid && s_ready, !s_ready, "accepted while busy")

endmodule

bind gear_ratio_matcher_core grm_checker u_grm_checker (.*);
